// ===== hdl/vtsg_pkg.sv =====
// Package for the text, semigraphic and graphic pixel generator.
// Holds the beat types, the command passed between front and back, and color
// constants and helpers. Depends on nothing.
`timescale 1ns / 1ps
package vtsg_pkg;

	localparam int VRAM_AW = 13;

	// Operation codes on the input beat.
	localparam logic [1:0] OP_VWR   = 2'd0;
	localparam logic [1:0] OP_FWR   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_TEXT_SEL = 2'd0;
	localparam logic [1:0] REG_MODE     = 2'd1;
	localparam logic [1:0] REG_COLOR    = 2'd2;

	// Logical palette indexes.
	localparam logic [3:0] C_BLACK  = 4'd0;
	localparam logic [3:0] C_GREEN  = 4'd1;
	localparam logic [3:0] C_BUFF   = 4'd5;
	localparam logic [3:0] C_CYAN   = 4'd6;
	localparam logic [3:0] C_ORANGE = 4'd7;
	localparam logic [3:0] C_LGREEN = 4'd10;

	// Address map and mode decode constants.
	localparam logic [VRAM_AW-1:0] ATTR_OFS  = 13'h0800;
	localparam logic [VRAM_AW-1:0] UDG_BASE  = 13'h1600;
	localparam logic [VRAM_AW-1:0] HIGH_BASE = 13'h1000;
	localparam logic [7:0] MODE_MASK  = 8'h8e;
	localparam logic [7:0] MODE_GFX4  = 8'h0e;
	localparam logic [7:0] MID_A      = 8'h80;
	localparam logic [7:0] MID_B      = 8'h0a;
	localparam logic [7:0] MID_C      = 8'h0c;
	localparam logic [7:0] MID_D      = 8'h8a;
	localparam logic [7:0] MID_E      = 8'h8c;
	localparam logic [7:0] CELL_RECIP = 8'd171;   // y/12 == (y*171) >> 11 for 8-bit y

	typedef struct packed {
		logic [1:0]  op;
		logic [12:0] address;
		logic [7:0]  data;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
	} in_t;

	typedef struct packed {
		logic [3:0] color_index;
		logic       drawn;
	} out_t;

	typedef enum logic [2:0] {
		K_VWR,
		K_FWR,
		K_TXT,
		K_GFX,
		K_NODRAW
	} kind_t;

	// One classified item. For writes addr/data are the write; for a text query
	// addr is the code byte address; for a graphic query addr is the pixel byte
	// address and data[3:0] the foreground color.
	typedef struct packed {
		kind_t                kind;
		logic [VRAM_AW-1:0]   addr;
		logic [7:0]           data;
		logic [2:0]           xb;
		logic [3:0]           yf;
	} cmd_t;

	typedef enum logic [1:0] {
		SRC_DIRECT,
		SRC_VRAM,
		SRC_FONT
	} src_t;

	function automatic logic [3:0] semi_color(input logic [2:0] k);
		logic [3:0] c;
		unique case (k)
			3'd6:    c = 4'd8;
			3'd7:    c = 4'd7;
			default: c = 4'({1'b0, k} + 4'd1);
		endcase
		return c;
	endfunction

	function automatic logic [7:0] semi_row(input logic [5:0] pat, input logic [3:0] row,
			input logic six);
		logic hi, lo;
		if (six) begin
			if (row < 4'd4) begin
				hi = pat[5]; lo = pat[4];
			end else if (row < 4'd8) begin
				hi = pat[3]; lo = pat[2];
			end else begin
				hi = pat[1]; lo = pat[0];
			end
		end else begin
			if (row < 4'd6) begin
				hi = pat[3]; lo = pat[2];
			end else begin
				hi = pat[1]; lo = pat[0];
			end
		end
		return {{4{hi}}, {4{lo}}};
	endfunction

endpackage

// ===== hdl/vtsg_front.sv =====
// Front end: accepts input beats, splits the query position into cell and row,
// classifies each item and queues it for the back end. Uses vtsg_pkg.
`timescale 1ns / 1ps
module vtsg_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  vtsg_pkg::in_t  item,
	input  logic           text_select,
	input  logic [7:0]     mode_code,
	input  logic [1:0]     color_mode,
	input  logic [1:0]     text_page,
	input  logic           hold,
	output logic           cmd_avail,
	output vtsg_pkg::cmd_t cmd_head,
	input  logic           cmd_take
);

	localparam int QD = 4;

	vtsg_pkg::cmd_t q_mem_q [QD];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	logic [15:0] prod;
	logic [4:0]  cell_row;
	logic [7:0]  cell_top;
	logic [3:0]  yf;
	logic [9:0]  offset;
	logic [12:0] taddr, gaddr;
	logic [7:0]  sel;
	logic        mid;
	logic [3:0]  gfg;
	logic        known, enq;
	vtsg_pkg::cmd_t c;

	always_comb begin
		prod     = 16'(item.pixel_y) * 16'(vtsg_pkg::CELL_RECIP);
		cell_row = prod[15:11];
		cell_top = 8'({cell_row, 3'b000}) + 8'({cell_row, 2'b00});
		yf       = 4'(item.pixel_y - cell_top);
		offset   = 10'({cell_row, 5'b00000}) + 10'(item.pixel_x[7:3]);
		taddr    = 13'({text_page, 9'b0}) + 13'(offset);
		gaddr    = 13'({item.pixel_y, 5'b00000}) + 13'(item.pixel_x[7:3]);
		sel      = mode_code & vtsg_pkg::MODE_MASK;
		mid      = (sel == vtsg_pkg::MID_A) || (sel == vtsg_pkg::MID_B) ||
			(sel == vtsg_pkg::MID_C) || (sel == vtsg_pkg::MID_D) ||
			(sel == vtsg_pkg::MID_E);
		if (sel == vtsg_pkg::MODE_GFX4) gfg = vtsg_pkg::C_GREEN;
		else gfg = (color_mode == 2'd0) ? vtsg_pkg::C_CYAN : vtsg_pkg::C_LGREEN;

		c.addr = item.address;
		c.data = item.data;
		c.xb   = item.pixel_x[2:0];
		c.yf   = yf;
		known  = 1'b1;
		unique case (item.op)
			vtsg_pkg::OP_VWR: c.kind = vtsg_pkg::K_VWR;
			vtsg_pkg::OP_FWR: c.kind = vtsg_pkg::K_FWR;
			vtsg_pkg::OP_QUERY: begin
				if (text_select) begin
					c.kind = vtsg_pkg::K_TXT;
					c.addr = taddr;
				end else if (mid) begin
					c.kind = vtsg_pkg::K_NODRAW;
				end else begin
					c.kind = vtsg_pkg::K_GFX;
					c.addr = gaddr;
					c.data = {4'b0000, gfg};
				end
			end
			default: begin
				c.kind = vtsg_pkg::K_NODRAW;
				known  = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == 3'(QD)) || hold;
	assign enq       = push && !full && known;
	assign cmd_avail = (cnt_q != 3'd0);
	assign cmd_head  = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq) q_mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) wp_q <= wp_q + 2'd1;
			if (cmd_take) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(enq) - 3'(cmd_take);
		end
	end

endmodule

// ===== hdl/vtsg_back.sv =====
// Back end: video memory (two copies), font memory, the read pipeline that turns
// a command into a pixel color, and the result queue. Uses vtsg_pkg.
`timescale 1ns / 1ps
module vtsg_back #(
	parameter int FONT_DEPTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      color_mode,
	output logic            clearing,
	input  logic            cmd_avail,
	input  vtsg_pkg::cmd_t  cmd_head,
	output logic            cmd_take,
	output logic            empty,
	input  logic            pop,
	output vtsg_pkg::out_t  result
);

	localparam int VD = 1 << vtsg_pkg::VRAM_AW;
	localparam int FW = $clog2(FONT_DEPTH);
	localparam int OD = 8;
	localparam int OW = $clog2(OD);

	logic [7:0] vram_a_q [VD];
	logic [7:0] vram_b_q [VD];
	logic [7:0] font_q [FONT_DEPTH];

	logic                      clr_q;
	logic [vtsg_pkg::VRAM_AW-1:0] clr_addr_q;

	// Stage 1: command plus code and attribute bytes.
	logic           v_s1;
	vtsg_pkg::cmd_t cmd_s1;
	logic [7:0]     code_s1, attr_s1;

	// Stage 2: row fetch results and colors.
	logic           v_s2;
	vtsg_pkg::src_t src_s2;
	logic [3:0]     fg_s2, bg_s2;
	logic [7:0]     row_s2, vb_s2, font_s2;
	logic [2:0]     xb_s2;
	logic           drawn_s2;

	vtsg_pkg::out_t obuf_q [OD];
	logic [OW-1:0]  owp_q, orp_q;
	logic [OW:0]    ocnt_q;

	logic [OW+1:0]  used;
	logic           q1;
	logic [vtsg_pkg::VRAM_AW-1:0] attr_addr;

	assign clearing  = clr_q;
	assign q1        = v_s1 && (cmd_s1.kind == vtsg_pkg::K_TXT || cmd_s1.kind == vtsg_pkg::K_GFX ||
		cmd_s1.kind == vtsg_pkg::K_NODRAW);
	assign used      = (OW+2)'(ocnt_q) + (OW+2)'(q1) + (OW+2)'(v_s2);
	assign cmd_take  = cmd_avail && !clr_q && (used < (OW+2)'(OD));
	assign attr_addr = cmd_head.addr + vtsg_pkg::ATTR_OFS;

	// Copy A: written and read at issue.
	always_ff @(posedge clk) begin
		if (clr_q) vram_a_q[clr_addr_q] <= 8'h00;
		else if (cmd_take && cmd_head.kind == vtsg_pkg::K_VWR)
			vram_a_q[cmd_head.addr] <= cmd_head.data;
		if (cmd_take) begin
			code_s1 <= vram_a_q[cmd_head.addr];
			attr_s1 <= vram_a_q[attr_addr];
			cmd_s1  <= cmd_head;
		end
	end

	// Stage 1 decode.
	logic [7:0]  c, cm;
	logic [3:0]  fg, bg, c2, c3;
	logic [7:0]  row;
	vtsg_pkg::src_t src;
	logic [vtsg_pkg::VRAM_AW-1:0] vaddr;
	logic [11:0] fidx;
	logic        drawn;

	always_comb begin
		c     = code_s1;
		cm    = 8'h00;
		fg    = vtsg_pkg::C_BLACK;
		bg    = vtsg_pkg::C_BLACK;
		row   = 8'h00;
		src   = vtsg_pkg::SRC_DIRECT;
		vaddr = '0;
		fidx  = '0;
		drawn = 1'b1;
		c2    = (color_mode >= 2'd2) ? vtsg_pkg::C_BUFF : vtsg_pkg::C_BLACK;
		c3    = (color_mode == 2'd0) ? vtsg_pkg::C_CYAN : vtsg_pkg::C_ORANGE;
		unique case (cmd_s1.kind)
			vtsg_pkg::K_TXT: begin
				if (attr_s1[2]) begin
					if (attr_s1[3]) begin
						fg  = vtsg_pkg::semi_color({attr_s1[1], code_s1[7:6]});
						row = vtsg_pkg::semi_row(code_s1[5:0], cmd_s1.yf, 1'b1);
					end else begin
						fg  = vtsg_pkg::semi_color(code_s1[6:4]);
						row = vtsg_pkg::semi_row({2'b00, code_s1[3:0]}, cmd_s1.yf, 1'b0);
					end
				end else begin
					unique case (attr_s1[1:0])
						2'd0: begin fg = vtsg_pkg::C_GREEN; bg = vtsg_pkg::C_BLACK; end
						2'd1: begin fg = vtsg_pkg::C_BLACK; bg = vtsg_pkg::C_GREEN; end
						2'd2: begin fg = c3; bg = c2; end
						default: begin fg = c2; bg = c3; end
					endcase
					if (c < 8'd32 && !attr_s1[3]) c = 8'd32;
					if (attr_s1[3] && c < 8'd96) c = c + 8'd128;
					if (c >= 8'd96 && c < 8'd128) begin
						src   = vtsg_pkg::SRC_VRAM;
						vaddr = vtsg_pkg::UDG_BASE + 13'({c[4:0], 4'b0000}) + 13'(cmd_s1.yf);
					end else if (c >= 8'd128 && c < 8'd224) begin
						src   = vtsg_pkg::SRC_VRAM;
						vaddr = vtsg_pkg::HIGH_BASE + 13'({c[6:0], 4'b0000}) + 13'(cmd_s1.yf);
					end else begin
						cm   = c - 8'd32;
						fidx = 12'({cm, 3'b000}) + 12'({cm, 2'b00}) + 12'(cmd_s1.yf);
						if (32'(fidx) < FONT_DEPTH) src = vtsg_pkg::SRC_FONT;
					end
				end
			end
			vtsg_pkg::K_GFX: begin
				fg  = cmd_s1.data[3:0];
				row = code_s1;
			end
			vtsg_pkg::K_NODRAW: drawn = 1'b0;
			default: drawn = 1'b1;
		endcase
	end

	// Copy B and font: written and read at stage 1.
	always_ff @(posedge clk) begin
		if (clr_q) vram_b_q[clr_addr_q] <= 8'h00;
		else if (v_s1 && cmd_s1.kind == vtsg_pkg::K_VWR)
			vram_b_q[cmd_s1.addr] <= cmd_s1.data;
		if (v_s1 && cmd_s1.kind == vtsg_pkg::K_FWR && 32'(cmd_s1.addr) < FONT_DEPTH)
			font_q[cmd_s1.addr[FW-1:0]] <= cmd_s1.data;
		if (q1) begin
			vb_s2    <= vram_b_q[vaddr];
			font_s2  <= font_q[fidx[FW-1:0]];
			src_s2   <= src;
			fg_s2    <= fg;
			bg_s2    <= bg;
			row_s2   <= row;
			xb_s2    <= cmd_s1.xb;
			drawn_s2 <= drawn;
		end
	end

	// Stage 2: pick the pixel bit.
	logic [7:0]     prow;
	vtsg_pkg::out_t px;

	always_comb begin
		unique case (src_s2)
			vtsg_pkg::SRC_VRAM: prow = vb_s2;
			vtsg_pkg::SRC_FONT: prow = font_s2;
			default:            prow = row_s2;
		endcase
		px.color_index = prow[3'd7 - xb_s2] ? fg_s2 : bg_s2;
		px.drawn       = drawn_s2;
	end

	logic opop;
	assign empty  = (ocnt_q == '0);
	assign opop   = pop && !empty;
	assign result = obuf_q[orp_q];

	always_ff @(posedge clk) begin
		if (v_s2) obuf_q[owp_q] <= px;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			owp_q      <= '0;
			orp_q      <= '0;
			ocnt_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) clr_q <= 1'b0;
			end
			v_s1 <= cmd_take;
			v_s2 <= q1;
			if (v_s2) owp_q <= owp_q + 1'b1;
			if (opop) orp_q <= orp_q + 1'b1;
			ocnt_q <= ocnt_q + (OW+1)'(v_s2) - (OW+1)'(opop);
		end
	end

endmodule

// ===== hdl/video_text_semigraphic_pixel_gen.sv =====
// Pixel generator for text, semigraphic and high-resolution graphic screens.
// After reset the block sweeps its 8 KB video memory to zero, one byte per
// cycle; full stays high during that sweep, while configuration writes are
// still taken. After that it accepts one beat per cycle while full is low:
// a video memory write, a font write, or a pixel query, whose result beat
// passes through the input queue, stage 1, stage 2 and the result buffer
// before it shows on the result ports. Throughput is one beat per cycle
// while full is low; each query makes a single read pass through video
// memory and font. Depends on vtsg_pkg, vtsg_front, vtsg_back.
`timescale 1ns / 1ps
module video_text_semigraphic_pixel_gen #(
	parameter int FONT_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  vtsg_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output vtsg_pkg::out_t result,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [7:0]     cfg_data
);

	// Configuration registers. The text page follows mode bits 5:4 after any
	// write to one of the three registers that leaves text mode selected.
	logic       text_select_q;
	logic [7:0] mode_code_q;
	logic [1:0] color_mode_q;
	logic [1:0] text_page_q;

	logic       ts_n;
	logic [7:0] mc_n;
	logic [1:0] cm_n;
	logic       reg_hit;

	always_comb begin
		ts_n    = text_select_q;
		mc_n    = mode_code_q;
		cm_n    = color_mode_q;
		reg_hit = 1'b1;
		unique case (cfg_index)
			vtsg_pkg::REG_TEXT_SEL: ts_n = cfg_data[0];
			vtsg_pkg::REG_MODE:     mc_n = cfg_data;
			vtsg_pkg::REG_COLOR:    cm_n = cfg_data[1:0];
			default:                reg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_select_q <= 1'b1;
			mode_code_q   <= 8'h00;
			color_mode_q  <= 2'd1;
			text_page_q   <= 2'd0;
		end else if (cfg_we && reg_hit) begin
			text_select_q <= ts_n;
			mode_code_q   <= mc_n;
			color_mode_q  <= cm_n;
			if (ts_n) text_page_q <= mc_n[5:4];
		end
	end

	logic           clearing;
	logic           cmd_avail, cmd_take;
	vtsg_pkg::cmd_t cmd_head;

	// The front classifies and queues items; the back runs the memories.
	vtsg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.text_select (text_select_q),
		.mode_code   (mode_code_q),
		.color_mode  (color_mode_q),
		.text_page   (text_page_q),
		.hold        (clearing),
		.cmd_avail   (cmd_avail),
		.cmd_head    (cmd_head),
		.cmd_take    (cmd_take)
	);

	vtsg_back #(
		.FONT_DEPTH (FONT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.color_mode (color_mode_q),
		.clearing   (clearing),
		.cmd_avail  (cmd_avail),
		.cmd_head   (cmd_head),
		.cmd_take   (cmd_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== hdl/vtsg_checker.sv =====
// Port-level checker for the pixel generator and its bind statement.
// Depends on vtsg_pkg and video_text_semigraphic_pixel_gen.
`timescale 1ns / 1ps
module vtsg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input vtsg_pkg::out_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result beat changed");

	a_nodraw_black: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.drawn |-> result.color_index == vtsg_pkg::C_BLACK)
		else $error("undrawn pixel carries a color");

	a_palette: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.color_index <= 4'd11)
		else $error("color index outside palette");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result present right after reset");

endmodule

bind video_text_semigraphic_pixel_gen vtsg_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the text, semigraphic and graphic pixel generator.
// Holds its own pixel predictor, a directed table, randomized phases and the
// scoreboard. Depends on vtsg_pkg and video_text_semigraphic_pixel_gen.
`timescale 1ns / 1ps
module tb_top;

	// Codes the package does not name: an op the block must ignore and a
	// register index beyond the last register.
	localparam logic [1:0] OP_NONE  = 2'd3;
	localparam logic [1:0] REG_NONE = 2'd3;
	// Font rows that get loaded: codes 32..39 and 224..227. Bytes that can
	// serve as character codes only ever take values that land there.
	localparam int FONT_LOW_END    = 96;
	localparam int FONT_HIGH_BEGIN = 2304;
	localparam int FONT_HIGH_END   = 2352;
	localparam int CODE_AREA_END   = 'h8c0;	// last code byte of page 3, plus one

	logic clk, arst_n;
	logic push, pop, cfg_we;
	logic full, empty;
	vtsg_pkg::in_t item;
	vtsg_pkg::out_t result;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	video_text_semigraphic_pixel_gen i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Period of 10 ns.
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Predictor copy of the block state and its registers.
	logic [7:0] vram_img [0:8191];
	logic [7:0] font_img [0:4095];
	logic [1:0] page_sh;
	logic text_sh;
	logic [7:0] mode_sh;
	logic [1:0] color_sh;

	vtsg_pkg::out_t pixel_q [$];	// expected pixels, oldest first

	int errors = 0;
	int n_beats = 0, n_pixels = 0, n_mid = 0, n_semi = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_req = 0;

	// One row of the directed table: either a register write or a beat, with
	// an optional expected pixel typed in by hand.
	typedef struct {
		bit         is_cfg;
		logic [1:0] idx;
		logic [7:0] val;
		logic [1:0] op;
		logic [12:0] addr;
		logic [7:0] data;
		logic [7:0] x;
		logic [7:0] y;
		bit         typed;
		logic [3:0] color;
		logic       drawn;
	} step_t;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Row pattern of a semigraphic block: each half of the row is lit when
	// its bit of the pattern is set.
	function automatic logic [7:0] block_row(input logic [5:0] pat, input int row,
			input bit six);
		int hi, lo;
		if (six) begin
			hi = (row < 4) ? 5 : (row < 8) ? 3 : 1;
		end else begin
			hi = (row < 6) ? 3 : 1;
		end
		lo = hi - 1;
		return {{4{pat[hi]}}, {4{pat[lo]}}};
	endfunction

	// Color of one pixel in text mode, from the current page of video memory.
	function automatic logic [3:0] text_color(input int x, input int y);
		int base, ofs, yf, code, attr, k;
		logic [3:0] fg, bg, c2, c3;
		logic [7:0] row;
		base = page_sh * 'h200;
		ofs = ((y / 12) << 5) + (x >> 3);
		yf = y % 12;
		code = vram_img[(base + ofs) & 8191];
		attr = vram_img[(base + vtsg_pkg::ATTR_OFS + ofs) & 8191];
		if (attr[2]) begin
			n_semi++;
			bg = vtsg_pkg::C_BLACK;
			if (attr[3]) begin
				k = ((attr & 2) << 1) | (code >> 6);
				row = block_row(code[5:0], yf, 1'b1);
			end else begin
				k = (code >> 4) & 7;
				row = block_row({2'b00, code[3:0]}, yf, 1'b0);
			end
			// Block colors run 1..8 with the last two swapped.
			fg = (k == 6) ? 4'd8 : (k == 7) ? 4'd7 : 4'(k + 1);
		end else begin
			c2 = (color_sh >= 2) ? vtsg_pkg::C_BUFF : vtsg_pkg::C_BLACK;
			c3 = (color_sh == 0) ? vtsg_pkg::C_CYAN : vtsg_pkg::C_ORANGE;
			case (attr & 3)
				0: begin fg = vtsg_pkg::C_GREEN; bg = vtsg_pkg::C_BLACK; end
				1: begin fg = vtsg_pkg::C_BLACK; bg = vtsg_pkg::C_GREEN; end
				2: begin fg = c3; bg = c2; end
				default: begin fg = c2; bg = c3; end
			endcase
			// Control codes show as blanks; the high set folds onto graphics.
			if (code < 32 && !attr[3]) code = 32;
			if (attr[3] && code < 96) code += 128;
			if (code >= 96 && code < 128) begin
				row = vram_img[(vtsg_pkg::UDG_BASE + (code - 96) * 16 + yf) & 8191];
			end else if (code >= 128 && code < 224) begin
				row = vram_img[(vtsg_pkg::HIGH_BASE + (code - 128) * 16 + yf) & 8191];
			end else begin
				row = font_img[(code - 32) * 12 + yf];
			end
		end
		return row[7 - (x & 7)] ? fg : bg;
	endfunction

	// Applies one accepted beat to the predictor; returns 1 with the expected
	// pixel when the beat is a query.
	function automatic bit predict_pixel(input vtsg_pkg::in_t b, output vtsg_pkg::out_t px);
		logic [7:0] sel, byte_v;
		logic [3:0] fg;
		px = '0;
		case (b.op)
			vtsg_pkg::OP_VWR: begin
				vram_img[b.address] = b.data;
				return 0;
			end
			vtsg_pkg::OP_FWR: begin
				if (b.address < 4096) font_img[b.address] = b.data;
				return 0;
			end
			vtsg_pkg::OP_QUERY: ;
			default: return 0;
		endcase
		px.drawn = 1'b1;
		if (text_sh) begin
			px.color_index = text_color(b.pixel_x, b.pixel_y);
		end else begin
			sel = mode_sh & vtsg_pkg::MODE_MASK;
			if (sel inside {vtsg_pkg::MID_A, vtsg_pkg::MID_B, vtsg_pkg::MID_C,
					vtsg_pkg::MID_D, vtsg_pkg::MID_E}) begin
				px.drawn = 1'b0;
				n_mid++;
			end else begin
				fg = (sel == vtsg_pkg::MODE_GFX4) ? vtsg_pkg::C_GREEN :
					(color_sh == 0) ? vtsg_pkg::C_CYAN : vtsg_pkg::C_LGREEN;
				byte_v = vram_img[13'((int'(b.pixel_y) << 5) + (b.pixel_x >> 3))];
				px.color_index = byte_v[7 - b.pixel_x[2:0]] ? fg : vtsg_pkg::C_BLACK;
			end
		end
		return 1;
	endfunction

	// Offers one beat, idling first at the current sender rate, and records
	// the expected pixel once the block takes it. push stays high afterwards
	// so that back-to-back beats need no extra step.
	task automatic send_beat(input vtsg_pkg::in_t b, input bit typed,
			input vtsg_pkg::out_t want);
		vtsg_pkg::out_t px;
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		item <= b;
		push <= 1'b1;
		do @(posedge clk); while (full);
		if (b.op != OP_NONE) n_beats++;
		if (predict_pixel(b, px)) pixel_q.push_back(typed ? want : px);
	endtask

	// Register write, only once the block has drained. A write gives no
	// result, so some extra cycles cover a write still in the pipeline.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		push <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vtsg_pkg::REG_TEXT_SEL: text_sh = val[0];
			vtsg_pkg::REG_MODE:     mode_sh = val;
			vtsg_pkg::REG_COLOR:    color_sh = val[1:0];
			default:                return;
		endcase
		if (text_sh) page_sh = mode_sh[5:4];
	endtask

	// Random beat that mostly lands where the current mode looks: the code and
	// attribute areas of the text page and the user character sets.
	function automatic vtsg_pkg::in_t random_beat();
		vtsg_pkg::in_t b;
		int r, base;
		b.data = 8'($urandom);
		b.pixel_x = 8'($urandom);
		b.pixel_y = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(192, 255))
			: 8'($urandom_range(0, 191));
		base = page_sh * 'h200;
		case ($urandom_range(0, 4))
			0: b.address = 13'(base + $urandom_range(0, 'h1ff));
			1: b.address = 13'(base + vtsg_pkg::ATTR_OFS + $urandom_range(0, 'h1ff));
			2: b.address = 13'(vtsg_pkg::HIGH_BASE + $urandom_range(0, 'hfff));
			default: b.address = 13'($urandom);
		endcase
		r = $urandom_range(0, 99);
		b.op = (r < 4) ? OP_NONE : (r < 40) ? vtsg_pkg::OP_VWR :
			(r < 46) ? vtsg_pkg::OP_FWR : vtsg_pkg::OP_QUERY;
		// A byte that some page may read as a character code takes a value
		// that either misses the font or hits one of the loaded rows.
		if (b.op == vtsg_pkg::OP_VWR && b.address < CODE_AREA_END) begin
			r = $urandom_range(0, 171);
			b.data = 8'((r < 40) ? r : r + 56);
		end
		return b;
	endfunction

	// Result side: checks each popped pixel against the oldest expectation
	// and decides pop for the next edge. A hold request starts a long stall
	// that fills the block up while the sender keeps offering beats.
	int hold_left = 0;
	always @(posedge clk) begin
		vtsg_pkg::out_t want;
		if (arst_n && pop && !empty) begin
			if (pixel_q.size() == 0) begin
				report_mismatch("unexpected pixel, color", result.color_index, -1);
			end else begin
				want = pixel_q.pop_front();
				n_pixels++;
				if (result.color_index !== want.color_index)
					report_mismatch("color_index", result.color_index, want.color_index);
				if (result.drawn !== want.drawn)
					report_mismatch("drawn", result.drawn, want.drawn);
			end
		end
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Hard limit well above the slowest legal run, clearing sweep included.
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	step_t directed [$];
	vtsg_pkg::in_t b;
	vtsg_pkg::out_t want;

	initial begin
		// Graphic mode first, on cleared memory, then the mode decode and
		// color choices, ignored beats and register writes, and finally each
		// text path on page 3: plain font, both block layouts, user sets.
		directed = '{
			'{1, vtsg_pkg::REG_TEXT_SEL, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, vtsg_pkg::REG_MODE, 8'h0e, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 0, 1, vtsg_pkg::C_BLACK, 1},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 255, 255, 1, vtsg_pkg::C_BLACK, 1},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 0, 8'h80, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 8191, 8'h01, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 0, 1, vtsg_pkg::C_GREEN, 1},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 255, 255, 1, vtsg_pkg::C_GREEN, 1},
			'{1, vtsg_pkg::REG_MODE, 8'h80, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 0, 1, vtsg_pkg::C_BLACK, 0},
			'{1, vtsg_pkg::REG_MODE, 8'h06, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 0, 1, vtsg_pkg::C_LGREEN, 1},
			'{1, vtsg_pkg::REG_COLOR, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 0, 1, vtsg_pkg::C_CYAN, 1},
			'{0, 0, 0, OP_NONE, 0, 8'hff, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_FWR, 13'h1fff, 8'hff, 0, 0, 0, 0, 0},
			'{1, REG_NONE, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, vtsg_pkg::REG_TEXT_SEL, 8'h01, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, vtsg_pkg::REG_MODE, 8'h30, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, vtsg_pkg::REG_COLOR, 8'h02, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'h600, 8'h26, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'he00, 8'h02, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 3, 5, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'he00, 8'h0c, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'h600, 8'hff, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'he00, 8'h04, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 4, 7, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'he00, 8'h00, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'h600, 8'd100, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'h1640, 8'haa, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'he00, 8'h08, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'h600, 8'h05, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'h1050, 8'h01, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 7, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'he00, 8'h00, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_VWR, 13'h600, 8'h00, 0, 0, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 1, 11, 0, 0, 0},
			'{0, 0, 0, vtsg_pkg::OP_QUERY, 0, 0, 0, 255, 0, 0, 0}
		};

		// Every input known from time zero; reset state mirrored.
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = vtsg_pkg::REG_TEXT_SEL;
		cfg_data = '0;
		foreach (vram_img[i]) vram_img[i] = '0;
		foreach (font_img[i]) font_img[i] = '0;
		page_sh = 2'd0;
		text_sh = 1'b1;
		mode_sh = 8'h00;
		color_sh = 2'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the font rows that queries can reach, so no query ever reads
		// an entry that was never written. The block takes these only after
		// its clearing sweep.
		for (int a = 0; a < FONT_LOW_END; a++) begin
			b = '{op: vtsg_pkg::OP_FWR, address: 13'(a), data: 8'($urandom),
				pixel_x: 0, pixel_y: 0};
			send_beat(b, 0, '0);
		end
		for (int a = FONT_HIGH_BEGIN; a < FONT_HIGH_END; a++) begin
			b = '{op: vtsg_pkg::OP_FWR, address: 13'(a), data: 8'($urandom),
				pixel_x: 0, pixel_y: 0};
			send_beat(b, 0, '0);
		end

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				write_reg(directed[i].idx, directed[i].val);
			end else begin
				b = '{op: directed[i].op, address: directed[i].addr, data: directed[i].data,
					pixel_x: directed[i].x, pixel_y: directed[i].y};
				want = '{color_index: directed[i].color, drawn: directed[i].drawn};
				send_beat(b, directed[i].typed, want);
			end
		end

		// Nine random phases: three with a sender faster than the receiver,
		// three the other way round, three at full rate. The first phases
		// pin the register extremes; later ones draw settings at random.
		for (int ph = 0; ph < 9; ph++) begin
			int cnt;
			send_idle = (ph < 3) ? 31 : (ph < 6) ? 72 : 0;
			recv_idle = (ph < 3) ? 72 : (ph < 6) ? 31 : 0;
			case (ph)
				0: begin
					write_reg(vtsg_pkg::REG_TEXT_SEL, 8'h01);
					write_reg(vtsg_pkg::REG_MODE, 8'hff);
					write_reg(vtsg_pkg::REG_COLOR, 8'h03);
				end
				1: begin
					write_reg(vtsg_pkg::REG_MODE, 8'h00);
					write_reg(vtsg_pkg::REG_COLOR, 8'h00);
				end
				2: begin
					write_reg(vtsg_pkg::REG_TEXT_SEL, 8'h00);
					write_reg(vtsg_pkg::REG_MODE, 8'h8e);
				end
				default: begin
					write_reg(vtsg_pkg::REG_TEXT_SEL, 8'($urandom_range(0, 1)));
					write_reg(vtsg_pkg::REG_MODE, 8'($urandom));
					write_reg(vtsg_pkg::REG_COLOR, 8'($urandom_range(0, 3)));
					if (ph == 4) write_reg(REG_NONE, 8'($urandom));
				end
			endcase
			// The long receiver stall falls in the first full-rate phase.
			if (ph == 6) hold_req = 1;
			cnt = 0;
			while (cnt < 64) begin
				b = random_beat();
				send_beat(b, 0, '0);
				if (b.op != OP_NONE) cnt++;
			end
		end

		push <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d beats and %0d checked pixels (%0d undrawn, %0d block cells)",
			n_beats, n_pixels, n_mid, n_semi);
		$display("across text pages, block layouts, user sets and graphic modes, all color modes.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
